// File: sv/fpa_pkg.sv
// Package for the fixed partition allocator.
// Holds the item structs, request and policy codes, controller types.
// No dependencies.
package fpa_pkg;

  localparam int unsigned MAX_PARTITIONS = 16;
  localparam int unsigned SIZE_BITS      = 16;
  localparam int unsigned IDX_BITS       = $clog2(MAX_PARTITIONS);
  localparam int unsigned CNT_BITS       = 5;

  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_ALLOC   = 2'd1;
  localparam logic [1:0] REQ_RESTORE = 2'd2;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_COUNT  = 1'b1;

  localparam logic [CNT_BITS-1:0] COUNT_RESET = CNT_BITS'(MAX_PARTITIONS);

  typedef struct packed {
    logic [1:0]           req_type;
    logic [IDX_BITS-1:0]  part_index;
    logic [SIZE_BITS-1:0] req_size;
  } fpa_in_t;

  typedef struct packed {
    logic                 granted;
    logic [IDX_BITS-1:0]  alloc_index;
    logic [SIZE_BITS-1:0] space_left;
  } fpa_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } fpa_state_t;

  typedef struct packed {
    logic load;
    logic restore;
    logic capture;
    logic step;
    logic commit;
  } fpa_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic scan_last;
  } fpa_sts_t;

endpackage

// File: sv/fpa_ctrl.sv
// Controller for the fixed partition allocator.
// Sequences load, restore and the per-entry allocate scan; uses fpa_pkg.
module fpa_ctrl import fpa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] req_type,
  input  fpa_sts_t   sts,
  output fpa_cmd_t   cmd,
  output logic       busy
);

  fpa_state_t state_r, state_nxt;
  logic       accept;

  assign accept = start && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && req_type == REQ_ALLOC) begin
          // no partition takes part: report no fit at once
          state_nxt = sts.cnt_zero ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy        = 1'b0;
        cmd.load    = accept && req_type == REQ_LOAD;
        cmd.restore = accept && req_type == REQ_RESTORE;
        cmd.capture = accept && req_type == REQ_ALLOC;
      end
      ST_SCAN: cmd.step   = 1'b1;
      ST_DONE: cmd.commit = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

// File: sv/fpa_dp.sv
// Datapath for the fixed partition allocator.
// Partition tables, scan index, fit tracking and result register; uses fpa_pkg.
module fpa_dp import fpa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  fpa_cmd_t            cmd,
  input  fpa_in_t             in_item,
  input  logic [1:0]          policy,
  input  logic [CNT_BITS-1:0] part_count,
  output fpa_sts_t            sts,
  output logic                out_valid,
  output fpa_out_t            out_item
);

  logic [SIZE_BITS-1:0] total_r [MAX_PARTITIONS];
  logic [SIZE_BITS-1:0] rem_r   [MAX_PARTITIONS];

  logic [IDX_BITS-1:0]  idx_r, pick_r;
  logic [SIZE_BITS-1:0] size_r, best_r;
  logic                 found_r;
  logic                 out_valid_r;
  fpa_out_t             out_r;

  logic [SIZE_BITS-1:0] cur;
  logic                 fits, better, take;

  assign cur  = rem_r[idx_r];
  assign fits = cur >= size_r;

  always_comb begin
    case (policy)
      POL_BEST:  better = cur < best_r;
      POL_WORST: better = cur > best_r;
      default:   better = 1'b0;
    endcase
  end

  assign take = fits && (!found_r || better);

  assign sts.cnt_zero  = part_count == '0;
  assign sts.scan_last = {1'b0, idx_r} == (part_count - CNT_BITS'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      total_r[in_item.part_index] <= in_item.req_size;
      rem_r[in_item.part_index]   <= in_item.req_size;
    end else if (cmd.restore) begin
      for (int i = 0; i < MAX_PARTITIONS; i++) begin
        rem_r[i] <= total_r[i];
      end
    end else if (cmd.commit && found_r) begin
      rem_r[pick_r] <= best_r - size_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      size_r  <= in_item.req_size;
      idx_r   <= '0;
      found_r <= 1'b0;
    end else if (cmd.step) begin
      idx_r <= idx_r + IDX_BITS'(1);
      if (take) begin
        found_r <= 1'b1;
        pick_r  <= idx_r;
        best_r  <= cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r.granted     <= found_r;
      out_r.alloc_index <= found_r ? pick_r : '0;
      out_r.space_left  <= found_r ? (best_r - size_r) : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// File: sv/fixed_partition_allocator_core.sv
// Fixed partition allocator: first, best or worst fit over a partition table.
// Load and restore only update the tables, no result; an allocate captures the
// request, scans the partitions in use (one table entry compared per cycle), then
// commits, result strobed once. Busy stays high until it is done; results cannot stall.
// Reset (rst_n, synchronous): policy first fit, 16 partitions, controller idle;
// partition tables are undefined until loaded. Uses fpa_pkg, fpa_ctrl, fpa_dp.
module fixed_partition_allocator_core import fpa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  fpa_in_t     in_data,
  output logic        out_valid,
  output fpa_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0]          policy_r;
  logic [CNT_BITS-1:0] count_r;
  logic [CNT_BITS-1:0] part_count;
  logic                wr_en;
  fpa_cmd_t            cmd;
  fpa_sts_t            sts;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_FIRST;
      count_r  <= COUNT_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_POLICY: policy_r <= pwdata[1:0];
        REG_COUNT:  count_r  <= pwdata[CNT_BITS-1:0];
        default:    policy_r <= policy_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_POLICY: prdata = {30'd0, policy_r};
      REG_COUNT:  prdata = {{(32-CNT_BITS){1'b0}}, count_r};
      default:    prdata = '0;
    endcase
  end

  // clamp the partition count to the table depth
  assign part_count = (count_r > COUNT_RESET) ? COUNT_RESET : count_r;

  fpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_data.req_type),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  fpa_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_item    (in_data),
    .policy     (policy_r),
    .part_count (part_count),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_item   (out_data)
  );

endmodule
